>>> hw/rtl/positional_list_engine_macros.svh
// ---------------------------------------------------------------------------
// positional_list_engine assertion macros
// shared property shapes for the list engine checkers
// ---------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_ENGINE_MACROS_SVH
`define POSITIONAL_LIST_ENGINE_MACROS_SVH

// same-cycle implication, disabled in reset
`define PLE_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("positional_list_engine: property failed");

// next-cycle implication, disabled in reset
`define PLE_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("positional_list_engine: property failed");

`endif

>>> hw/rtl/ple_pkg.sv
// ---------------------------------------------------------------------------
// ple_pkg
// field widths and operation / status codes of the list engine
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ple_pkg;

    // item field widths
    localparam int OP_W    = 3;
    localparam int VALUE_W = 32;
    localparam int POS_W   = 10;
    localparam int STAT_W  = 2;
    localparam int MIDX_W  = 8;
    localparam int CNT_W   = 9;

    // operation codes
    typedef enum logic [OP_W-1:0] {
        OP_ADD_HEAD    = 3'd0,
        OP_ADD_TAIL    = 3'd1,
        OP_INSERT_AT   = 3'd2,
        OP_REMOVE_HEAD = 3'd3,
        OP_REMOVE_TAIL = 3'd4,
        OP_REMOVE_AT   = 3'd5,
        OP_SEARCH      = 3'd6
    } op_t;

    // result status codes
    typedef enum logic [STAT_W-1:0] {
        ST_DONE     = 2'd0,
        ST_FULL     = 2'd1,
        ST_NOCHANGE = 2'd2
    } status_t;

endpackage

`default_nettype wire

>>> hw/rtl/ple_ram.sv
// ---------------------------------------------------------------------------
// ple_ram
// simple dual-port ram, one write and one registered read per cycle
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ple_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> hw/rtl/positional_list_engine.sv
// ---------------------------------------------------------------------------
// positional_list_engine
// ordered list of signed 32-bit values with positional insert, remove and search
// ---------------------------------------------------------------------------
//  channel  | ports                                      | direction
//  ---------+--------------------------------------------+----------
//  s_       | s_valid s_ready s_opcode s_value s_position | in
//  m_       | m_valid m_ready m_status m_found            | out
//           | m_match_index m_entry_count                 |
//
//  one item at a time; the entries sit in one ram with a single write and a
//  single registered read port, and every shift or scan step moves one entry
//  per cycle through it
//  insert moves the entries from the position up, then places the value,
//  remove moves later entries down, search scans until a hit or the tail
//  reset clears the entry count and the control state, ram contents are kept
//  a finished result waits in the output register; s_ready stays low while
//  that register is full and the next result is ready
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module positional_list_engine
    import ple_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire logic [OP_W-1:0]           s_opcode,
    input  wire logic signed [VALUE_W-1:0] s_value,
    input  wire logic [POS_W-1:0]          s_position,
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output logic [STAT_W-1:0]              m_status,
    output logic                           m_found,
    output logic [MIDX_W-1:0]              m_match_index,
    output logic [CNT_W-1:0]               m_entry_count
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    // sequencer states
    typedef enum logic [5:0] {
        S_IDLE     = 6'b000001,
        S_SHIFT_UP = 6'b000010,
        S_PLACE    = 6'b000100,
        S_SHIFT_DN = 6'b001000,
        S_SCAN     = 6'b010000,
        S_DONE     = 6'b100000
    } state_t;

    state_t                     state_reg, state_next;
    logic [CW-1:0]              count_reg, count_next;
    logic [CW-1:0]              idx_reg, idx_next;
    logic [CW-1:0]              at_reg, at_next;
    logic                       pend_reg, pend_next;
    logic [IW-1:0]              pend_addr_reg, pend_addr_next;
    logic signed [VALUE_W-1:0]  val_reg, val_next;
    status_t                    st_reg, st_next;
    logic                       found_reg, found_next;
    logic [IW-1:0]              midx_reg, midx_next;
    logic                       m_valid_reg, m_valid_next;
    logic [STAT_W-1:0]          out_status_reg, out_status_next;
    logic                       out_found_reg, out_found_next;
    logic [MIDX_W-1:0]          out_midx_reg, out_midx_next;
    logic [CNT_W-1:0]           out_count_reg, out_count_next;

    logic                       ram_we;
    logic [IW-1:0]              ram_waddr;
    logic [VALUE_W-1:0]         ram_wdata;
    logic [IW-1:0]              ram_raddr;
    logic [VALUE_W-1:0]         ram_rdata;

    logic                       list_full;
    logic                       list_empty;
    logic [CW-1:0]              last_idx;
    logic [CW-1:0]              ins_at;
    logic [CW-1:0]              rem_at;
    logic [CW-1:0]              idx_m1;
    logic [CW-1:0]              idx_p1;
    op_t                        op;

    // entry storage
    ple_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // list status and clamped positions
    assign op         = op_t'(s_opcode);
    assign list_full  = (count_reg == CW'(DEPTH));
    assign list_empty = (count_reg == '0);
    assign last_idx   = count_reg - CW'(1);
    assign idx_m1     = idx_reg - CW'(1);
    assign idx_p1     = idx_reg + CW'(1);
    assign ins_at     = (s_position > POS_W'(count_reg)) ? count_reg : s_position[CW-1:0];
    assign rem_at     = (s_position > POS_W'(last_idx)) ? last_idx : s_position[CW-1:0];

    // sequencer
    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        at_next         = at_reg;
        pend_next       = 1'b0;
        pend_addr_next  = pend_addr_reg;
        val_next        = val_reg;
        st_next         = st_reg;
        found_next      = found_reg;
        midx_next       = midx_reg;
        m_valid_next    = m_valid_reg & ~m_ready;
        out_status_next = out_status_reg;
        out_found_next  = out_found_reg;
        out_midx_next   = out_midx_reg;
        out_count_next  = out_count_reg;
        ram_we          = 1'b0;
        ram_waddr       = pend_addr_reg;
        ram_wdata       = ram_rdata;
        ram_raddr       = '0;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    val_next   = s_value;
                    st_next    = ST_DONE;
                    found_next = 1'b0;
                    midx_next  = '0;
                    case (op) inside
                        OP_ADD_HEAD, OP_ADD_TAIL, OP_INSERT_AT: begin
                            if (list_full) begin
                                st_next    = ST_FULL;
                                state_next = S_DONE;
                            end else begin
                                idx_next   = count_reg;
                                state_next = S_SHIFT_UP;
                                case (op)
                                    OP_ADD_HEAD: at_next = '0;
                                    OP_ADD_TAIL: at_next = count_reg;
                                    default:     at_next = ins_at;
                                endcase
                            end
                        end
                        OP_REMOVE_HEAD, OP_REMOVE_TAIL: begin
                            if (list_empty) begin
                                st_next    = ST_NOCHANGE;
                                state_next = S_DONE;
                            end else begin
                                idx_next   = (op == OP_REMOVE_HEAD) ? '0 : last_idx;
                                state_next = S_SHIFT_DN;
                            end
                        end
                        OP_REMOVE_AT: begin
                            if (list_empty || rem_at == '0) begin
                                st_next    = ST_NOCHANGE;
                                state_next = S_DONE;
                            end else begin
                                idx_next   = rem_at;
                                state_next = S_SHIFT_DN;
                            end
                        end
                        OP_SEARCH: begin
                            idx_next   = '0;
                            state_next = S_SCAN;
                        end
                        default: begin
                            st_next    = ST_NOCHANGE;
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            // move entries up one place, tail first
            S_SHIFT_UP: begin
                ram_we = pend_reg;
                if (idx_reg != at_reg) begin
                    ram_raddr      = idx_m1[IW-1:0];
                    pend_next      = 1'b1;
                    pend_addr_next = idx_reg[IW-1:0];
                    idx_next       = idx_m1;
                end else begin
                    state_next = S_PLACE;
                end
            end

            // write the new value into the opened slot
            S_PLACE: begin
                ram_we     = 1'b1;
                ram_waddr  = at_reg[IW-1:0];
                ram_wdata  = val_reg;
                count_next = count_reg + CW'(1);
                state_next = S_DONE;
            end

            // move entries down one place over the removed slot
            S_SHIFT_DN: begin
                ram_we = pend_reg;
                if (idx_p1 < count_reg) begin
                    ram_raddr      = idx_p1[IW-1:0];
                    pend_next      = 1'b1;
                    pend_addr_next = idx_reg[IW-1:0];
                    idx_next       = idx_p1;
                end else begin
                    count_next = last_idx;
                    state_next = S_DONE;
                end
            end

            // compare one entry a cycle from the head
            S_SCAN: begin
                if (pend_reg && ram_rdata == val_reg) begin
                    found_next = 1'b1;
                    midx_next  = pend_addr_reg;
                    state_next = S_DONE;
                end else if (idx_reg < count_reg) begin
                    ram_raddr      = idx_reg[IW-1:0];
                    pend_next      = 1'b1;
                    pend_addr_next = idx_reg[IW-1:0];
                    idx_next       = idx_p1;
                end else begin
                    state_next = S_DONE;
                end
            end

            // hand the result to the output register once it is free
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next    = 1'b1;
                    out_status_next = st_reg;
                    out_found_next  = found_reg;
                    out_midx_next   = MIDX_W'(midx_reg);
                    out_count_next  = CNT_W'(count_reg);
                    state_next      = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // working and result registers
    always_ff @(posedge aclk) begin
        idx_reg        <= idx_next;
        at_reg         <= at_next;
        pend_addr_reg  <= pend_addr_next;
        val_reg        <= val_next;
        st_reg         <= st_next;
        found_reg      <= found_next;
        midx_reg       <= midx_next;
        out_status_reg <= out_status_next;
        out_found_reg  <= out_found_next;
        out_midx_reg   <= out_midx_next;
        out_count_reg  <= out_count_next;
    end

    // ports
    assign s_ready       = (state_reg == S_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_status      = out_status_reg;
    assign m_found       = out_found_reg;
    assign m_match_index = out_midx_reg;
    assign m_entry_count = out_count_reg;

endmodule

`default_nettype wire

>>> hw/rtl/ple_checker.sv
// ---------------------------------------------------------------------------
// ple_checker
// port-level checks on the list engine results, bound to the top level
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "positional_list_engine_macros.svh"

module ple_checker
    import ple_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input wire logic                      aclk,
    input wire logic                      aresetn,
    input wire logic                      s_valid,
    input wire logic                      s_ready,
    input wire logic [OP_W-1:0]           s_opcode,
    input wire logic signed [VALUE_W-1:0] s_value,
    input wire logic [POS_W-1:0]          s_position,
    input wire logic                      m_valid,
    input wire logic                      m_ready,
    input wire logic [STAT_W-1:0]         m_status,
    input wire logic                      m_found,
    input wire logic [MIDX_W-1:0]         m_match_index,
    input wire logic [CNT_W-1:0]          m_entry_count
);

    logic [OP_W+VALUE_W+POS_W-1:0] s_payload;
    logic [STAT_W+MIDX_W+CNT_W:0]  m_payload;
    logic                          at_cap;
    logic                          hit_ok;
    logic                          index_ok;

    // packed views of both channels and derived flags
    assign s_payload = {s_opcode, s_value, s_position};
    assign m_payload = {m_status, m_found, m_match_index, m_entry_count};
    assign at_cap    = (m_entry_count == CNT_W'(DEPTH));
    assign hit_ok    = (m_status == ST_DONE) && (CNT_W'(m_match_index) < m_entry_count);
    assign index_ok  = m_found ? hit_ok : (m_match_index == '0);

    // count never exceeds the list capacity
    `PLE_ASSERT_NOW(a_count_cap, aclk, aresetn, m_valid, m_entry_count <= CNT_W'(DEPTH))

    // a rejected insert only happens on a full list
    `PLE_ASSERT_NOW(a_full_count, aclk, aresetn, m_valid && m_status == ST_FULL, at_cap)

    // a hit points inside the list and completes normally, a miss reports index zero
    `PLE_ASSERT_NOW(a_match_index, aclk, aresetn, m_valid, index_ok)

    // a stalled result holds its fields
    `PLE_ASSERT_NXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_payload))

    // a waiting input item holds its fields
    `PLE_ASSERT_NXT(a_in_hold, aclk, aresetn, s_valid && !s_ready, s_valid && $stable(s_payload))

endmodule

bind positional_list_engine ple_checker #(
    .DEPTH (DEPTH)
) u_ple_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .s_opcode      (s_opcode),
    .s_value       (s_value),
    .s_position    (s_position),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_status      (m_status),
    .m_found       (m_found),
    .m_match_index (m_match_index),
    .m_entry_count (m_entry_count)
);

`default_nettype wire
